### rtl/hrv_pkg.sv
// ----------------------------------------------------------------------------
// hrv_pkg
// Shared types and constants for the header record validator.
// ----------------------------------------------------------------------------
package hrv_pkg;

    localparam int unsigned OFS_W = 5;

    // Record layout
    localparam logic [OFS_W-1:0] OFS_FIRST     = 5'd0;
    localparam logic [OFS_W-1:0] OFS_MAP_FLAG  = 5'd19;
    localparam logic [OFS_W-1:0] OFS_ZERO_BYTE = 5'd20;
    localparam logic [OFS_W-1:0] OFS_ROM_KIND  = 5'd21;
    localparam logic [OFS_W-1:0] OFS_TYPE_LO   = 5'd22;
    localparam logic [OFS_W-1:0] OFS_TYPE_HI   = 5'd23;
    localparam logic [OFS_W-1:0] OFS_SIZE      = 5'd24;
    localparam logic [OFS_W-1:0] OFS_REGION    = 5'd25;
    localparam logic [OFS_W-1:0] OFS_LAST      = 5'd26;
    localparam logic [OFS_W-1:0] OFS_DONE      = 5'd27;

    // Name scanner
    localparam logic [5:0] NAME_BUDGET_INIT = 6'd16;
    localparam logic [4:0] COUNT_MAX        = 5'd31;
    localparam logic [4:0] COUNT_SPECIAL    = 5'd11;
    localparam logic [7:0] CTRL_LIMIT       = 8'h20;
    localparam logic [7:0] ASCII_LIMIT      = 8'h80;
    localparam logic [7:0] KANA_BASE        = 8'ha0;
    localparam logic [7:0] KANA_SPAN        = 8'h50;
    localparam logic [7:0] LEAD_TEST        = 8'h40;

    localparam logic [1:0] NAME_OK     = 2'd0;
    localparam logic [1:0] NAME_REJECT = 2'd1;
    localparam logic [1:0] NAME_EARLY  = 2'd2;

    // Field checks
    localparam logic [15:0] TYPE_MASK     = 16'h040f;
    localparam logic [7:0]  TYPE_LO_MAX   = 8'hc0;
    localparam logic [7:0]  SIZE_BAD_MASK = 8'hce;
    localparam logic [7:0]  SIZE_REQ_MASK = 8'h30;
    localparam logic [7:0]  REGION_MASK   = 8'h4f;
    localparam logic [7:0]  LAST_VALUE    = 8'h33;

    // Per-cycle step control from the top level to the checking units
    typedef struct packed {
        logic go;       // process the staged word against the record state
        logic restart;  // staged word is offset 0: start from reset state
    } hrv_step_t;

endpackage

### rtl/hrv_name_scan.sv
// ----------------------------------------------------------------------------
// hrv_name_scan
// Name scanner: budget, character count, lead/trail pairing and end status.
// ----------------------------------------------------------------------------
module hrv_name_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  hrv_pkg::hrv_step_t step,
    input  logic [7:0]        byte_value,
    output logic [1:0]        status_next
);
    import hrv_pkg::*;

    logic [5:0] budget_reg, budget_next;
    logic [4:0] count_reg, count_next;
    logic       lead_reg, lead_next;
    logic       fin_reg, fin_next;
    logic [1:0] code_reg, code_next;

    logic [5:0] budget_cur;
    logic [4:0] count_cur;
    logic       lead_cur;
    logic       fin_cur;
    logic [1:0] code_cur;

    // Start from the reset state on a record start
    assign budget_cur = step.restart ? NAME_BUDGET_INIT : budget_reg;
    assign count_cur  = step.restart ? 5'd0 : count_reg;
    assign lead_cur   = step.restart ? 1'b0 : lead_reg;
    assign fin_cur    = step.restart ? 1'b0 : fin_reg;
    assign code_cur   = step.restart ? NAME_OK : code_reg;

    always_comb
    begin
        logic [1:0] cost;
        logic       do_spend;
        logic       end_now;
        logic [1:0] end_code;
        logic [7:0] lead_probe;
        logic [7:0] kana_probe;

        cost        = 2'd1;
        do_spend    = 1'b0;
        end_now     = 1'b0;
        end_code    = NAME_OK;
        lead_probe  = byte_value - CTRL_LIMIT;
        kana_probe  = byte_value - KANA_BASE;
        budget_next = budget_cur;
        count_next  = count_cur;
        lead_next   = lead_cur;
        fin_next    = fin_cur;
        code_next   = code_cur;

        if (!fin_cur) begin
            if (lead_cur) begin
                lead_next = 1'b0;
                if (byte_value < CTRL_LIMIT && count_cur != COUNT_SPECIAL) begin
                    end_now  = 1'b1;
                    end_code = NAME_REJECT;
                end
                else if (byte_value < CTRL_LIMIT && byte_value != 8'h00) begin
                    end_now  = 1'b1;
                    end_code = NAME_EARLY;
                end
                else begin
                    if (count_cur != COUNT_MAX)
                        count_next = count_cur + 5'd1;
                    cost     = 2'd2;
                    do_spend = 1'b1;
                end
            end
            else if (byte_value[7] && (lead_probe & LEAD_TEST) != 8'h00) begin
                lead_next = 1'b1;
            end
            else if (byte_value == 8'h00) begin
                if (count_cur == 5'd0) begin
                    end_now  = 1'b1;
                    end_code = NAME_REJECT;
                end
                else begin
                    do_spend = 1'b1;
                end
            end
            else if (byte_value < CTRL_LIMIT) begin
                end_now  = 1'b1;
                end_code = NAME_REJECT;
            end
            else if (byte_value < ASCII_LIMIT) begin
                if (count_cur != COUNT_MAX)
                    count_next = count_cur + 5'd1;
                do_spend = 1'b1;
            end
            else if (kana_probe < KANA_SPAN) begin
                do_spend = 1'b1;
            end
            else begin
                end_now  = 1'b1;
                end_code = NAME_REJECT;
            end

            // Budget used up ends the scan
            if (do_spend) begin
                if (budget_cur <= {4'd0, cost}) begin
                    budget_next = 6'd0;
                    end_now     = 1'b1;
                    end_code    = (count_next != 5'd0) ? NAME_OK : NAME_REJECT;
                end
                else begin
                    budget_next = budget_cur - {4'd0, cost};
                end
            end

            if (end_now) begin
                fin_next  = 1'b1;
                code_next = end_code;
            end
        end
    end

    assign status_next = fin_next ? code_next : NAME_REJECT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            budget_reg <= NAME_BUDGET_INIT;
            count_reg  <= 5'd0;
            lead_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            code_reg   <= NAME_OK;
        end
        else if (step.go) begin
            budget_reg <= budget_next;
            count_reg  <= count_next;
            lead_reg   <= lead_next;
            fin_reg    <= fin_next;
            code_reg   <= code_next;
        end
    end

endmodule

### rtl/hrv_field_check.sv
// ----------------------------------------------------------------------------
// hrv_field_check
// Fixed-offset field checks over offsets 19 to 26 with a sticky fail flag.
// ----------------------------------------------------------------------------
module hrv_field_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hrv_pkg::hrv_step_t        step,
    input  logic [hrv_pkg::OFS_W-1:0] offset,
    input  logic [7:0]                byte_value,
    output logic                      failed_next
);
    import hrv_pkg::*;

    logic       failed_reg;
    logic [7:0] type_lo_reg, type_lo_next;
    logic       failed_cur;
    logic [7:0] type_lo_cur;
    logic       bad;

    assign failed_cur  = step.restart ? 1'b0 : failed_reg;
    assign type_lo_cur = step.restart ? 8'h00 : type_lo_reg;

    always_comb
    begin
        logic [15:0] type_pair;

        type_pair    = {byte_value, type_lo_cur};
        bad          = 1'b0;
        type_lo_next = type_lo_cur;
        case (offset)
            OFS_MAP_FLAG:  bad = (byte_value != 8'h00 && byte_value != 8'hff);
            OFS_ZERO_BYTE: bad = (byte_value != 8'h00);
            OFS_ROM_KIND:  bad = (byte_value[1:0] != 2'b00);
            OFS_TYPE_LO:   type_lo_next = byte_value;
            OFS_TYPE_HI:
            begin
                // All-zero and all-one pairs always pass
                if (type_pair != 16'h0000 && type_pair != 16'hffff)
                    bad = ((type_pair & TYPE_MASK) != 16'h0000)
                          || (type_pair[7:0] > TYPE_LO_MAX);
            end
            OFS_SIZE:      bad = ((byte_value & SIZE_BAD_MASK) != 8'h00)
                                 || ((byte_value & SIZE_REQ_MASK) == 8'h00);
            OFS_REGION:    bad = ((byte_value & REGION_MASK) != 8'h00);
            OFS_LAST:      bad = (byte_value != LAST_VALUE && byte_value != 8'hff);
            default:       bad = 1'b0;
        endcase
    end

    assign failed_next = failed_cur | bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            failed_reg  <= 1'b0;
            type_lo_reg <= 8'h00;
        end
        else if (step.go) begin
            failed_reg  <= failed_next;
            type_lo_reg <= type_lo_next;
        end
    end

endmodule

### rtl/header_record_validator.sv
// ----------------------------------------------------------------------------
// header_record_validator
// Streams a 27-byte header record and reports one verdict per record.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle with no gaps needed. Each word is held in an
// input register, then checked against the name scanner and the field checks;
// the verdict for offset 26 lands in an output register once that byte leaves
// the input register. Input stalls only while a completed verdict is still
// waiting and the next staged byte would produce another. Bytes past offset 26
// are dropped until record_start marks a new record; without any record_start,
// the first byte after reset is offset 0.
module header_record_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] byte_value,
    input  logic       record_start,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       header_ok,
    output logic [1:0] name_status,
    output logic       fields_ok
);
    import hrv_pkg::*;

    logic             stage_valid_reg, stage_valid_next;
    logic [7:0]       stage_byte_reg;
    logic             stage_start_reg;
    logic [OFS_W-1:0] offset_reg;
    logic [OFS_W-1:0] offset_cur;
    logic             active;
    logic             last_byte;
    logic             blocked;
    logic             fire;
    logic             accept;
    hrv_step_t        step;

    logic [1:0]       status_next;
    logic             failed_next;

    logic             out_valid_reg, out_valid_next;
    logic             header_ok_reg;
    logic [1:0]       name_status_reg;
    logic             fields_ok_reg;

    assign offset_cur = stage_start_reg ? OFS_FIRST : offset_reg;
    assign active     = (offset_cur <= OFS_LAST);
    assign last_byte  = active && (offset_cur == OFS_LAST);

    // Hold the staged word only if it carries a verdict with nowhere to go
    assign blocked    = last_byte && out_valid_reg && verdict_stall;
    assign fire       = stage_valid_reg && !blocked;
    assign byte_stall = stage_valid_reg && blocked;
    assign accept     = byte_valid && !byte_stall;

    assign step.go      = fire && active;
    assign step.restart = stage_start_reg;

    hrv_name_scan u_name_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .byte_value  (stage_byte_reg),
        .status_next (status_next)
    );

    hrv_field_check u_field_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .offset      (offset_cur),
        .byte_value  (stage_byte_reg),
        .failed_next (failed_next)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (fire)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && last_byte)
            out_valid_next = 1'b1;
        else if (!verdict_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            offset_reg      <= OFS_FIRST;
            out_valid_reg   <= 1'b0;
        end
        else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (step.go)
                offset_reg <= offset_cur + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            stage_byte_reg  <= byte_value;
            stage_start_reg <= record_start;
        end
        if (fire && last_byte) begin
            name_status_reg <= status_next;
            fields_ok_reg   <= !failed_next;
            header_ok_reg   <= !failed_next && (status_next == NAME_OK);
        end
    end

    assign verdict_valid = out_valid_reg;
    assign header_ok     = header_ok_reg;
    assign name_status   = name_status_reg;
    assign fields_ok     = fields_ok_reg;

endmodule

### rtl/hrv_checker.sv
// ----------------------------------------------------------------------------
// hrv_checker
// Port-level checks for the header record validator, bound to the top level.
// ----------------------------------------------------------------------------
module hrv_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic       verdict_valid,
    input  logic       verdict_stall,
    input  logic       header_ok,
    input  logic [1:0] name_status,
    input  logic       fields_ok
);
    import hrv_pkg::*;

    // Pass verdict only when fields pass and the name scan is ok
    a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (header_ok == (fields_ok && name_status == NAME_OK)))
        else $error("header_ok disagrees with fields_ok and name_status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (name_status == NAME_OK || name_status == NAME_REJECT
                           || name_status == NAME_EARLY))
        else $error("name_status carries an undefined code");

    // Input only backs up behind a waiting verdict word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (verdict_valid && verdict_stall))
        else $error("byte_stall without a stalled verdict");

    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict_stall) |=> (verdict_valid && $stable(header_ok)
            && $stable(name_status) && $stable(fields_ok)))
        else $error("stalled verdict word changed");

    a_no_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!verdict_valid && !byte_valid) |=> !byte_stall)
        else $error("byte_stall with no pending work");

endmodule

bind header_record_validator hrv_checker u_hrv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .header_ok     (header_ok),
    .name_status   (name_status),
    .fields_ok     (fields_ok)
);

### tb/header_record_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_record_validator_tb
// Streams header records into the validator and checks every verdict.
// A table of directed records comes first: field extremes, name scan rules,
// truncated records and trailing bytes. Random records follow, mostly well
// formed with random content. Verdicts are checked against a row's own verdict
// if given, else a predictor that tracks name scan and fields on its own state.
// ----------------------------------------------------------------------------
module header_record_validator_tb;
    import hrv_pkg::*;

    localparam int ITEMS = 1850;

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
        logic       fok;
    } verdict_t;

    typedef struct packed {
        bit [8*19-1:0] name;
        bit [63:0]     fld;
        bit            start;
        bit [4:0]      nbytes;
        bit [3:0]      junk;
        bit            known;
        verdict_t      want;
    } record_row_t;

    localparam bit [8*19-1:0] NM_A = "ABCDEFGHIJKLMNOPQRS";
    localparam bit [63:0] FG = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h00, 8'h33};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] byte_value = 8'h00;
    logic       record_start = 1'b0;
    logic       verdict_valid;
    logic       verdict_stall = 1'b0;
    logic       header_ok;
    logic [1:0] name_status;
    logic       fields_ok;

    header_record_validator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .record_start  (record_start),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .header_ok     (header_ok),
        .name_status   (name_status),
        .fields_ok     (fields_ok)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [4:0] rec_pos;
    logic [5:0] units_left;
    logic [4:0] char_tally;
    logic       lead_wait;
    logic       scan_done;
    logic [1:0] scan_code;
    logic       field_bad;
    logic [7:0] type_lo;

    verdict_t    pending_verdicts [$];
    int          errors = 0;
    int          scored_words = 0;
    bit          idle_on = 1'b1;
    logic [7:0]  rec_buf [0:26];
    record_row_t dir_tab [0:22];

    task clear_record;
    begin
        rec_pos    = OFS_FIRST;
        units_left = NAME_BUDGET_INIT;
        char_tally = 5'd0;
        lead_wait  = 1'b0;
        scan_done  = 1'b0;
        scan_code  = NAME_OK;
        field_bad  = 1'b0;
        type_lo    = 8'h00;
    end
    endtask

    task end_scan(input logic [1:0] code);
    begin
        scan_done = 1'b1;
        scan_code = code;
    end
    endtask

    task bump_tally;
    begin
        if (char_tally < COUNT_MAX)
            char_tally = char_tally + 5'd1;
    end
    endtask

    task charge_units(input logic [5:0] cost);
    begin
        if (units_left <= cost)
        begin
            units_left = 6'd0;
            end_scan((char_tally != 5'd0) ? NAME_OK : NAME_REJECT);
        end
        else
            units_left = units_left - cost;
    end
    endtask

    task scan_name(input logic [7:0] c);
        logic [7:0] shifted;
        logic [7:0] kana_ofs;
    begin
        shifted  = c - CTRL_LIMIT;
        kana_ofs = c - KANA_BASE;
        if (!scan_done)
        begin
            if (lead_wait)
            begin
                lead_wait = 1'b0;
                if (c < CTRL_LIMIT && char_tally != COUNT_SPECIAL)
                    end_scan(NAME_REJECT);
                else if (c < CTRL_LIMIT && c != 8'h00)
                    end_scan(NAME_EARLY);
                else
                begin
                    bump_tally();
                    charge_units(6'd2);
                end
            end
            else if (c[7] && (shifted & LEAD_TEST) != 8'h00)
                lead_wait = 1'b1;
            else if (c == 8'h00)
            begin
                if (char_tally == 5'd0)
                    end_scan(NAME_REJECT);
                else
                    charge_units(6'd1);
            end
            else if (c < CTRL_LIMIT)
                end_scan(NAME_REJECT);
            else if (c < ASCII_LIMIT)
            begin
                bump_tally();
                charge_units(6'd1);
            end
            else if (kana_ofs < KANA_SPAN)
                charge_units(6'd1);
            else
                end_scan(NAME_REJECT);
        end
    end
    endtask

    task check_field(input logic [4:0] ofs, input logic [7:0] b);
        logic [15:0] pair;
        logic        bad;
    begin
        bad  = 1'b0;
        pair = {b, type_lo};
        case (ofs)
            OFS_MAP_FLAG:  bad = (b != 8'h00 && b != 8'hff);
            OFS_ZERO_BYTE: bad = (b != 8'h00);
            OFS_ROM_KIND:  bad = (b[1:0] != 2'b00);
            OFS_TYPE_LO:   type_lo = b;
            OFS_TYPE_HI:
            begin
                if (pair != 16'h0000 && pair != 16'hffff)
                    bad = ((pair & TYPE_MASK) != 16'h0000) || (type_lo > TYPE_LO_MAX);
            end
            OFS_SIZE:      bad = ((b & SIZE_BAD_MASK) != 8'h00) ||
                                 ((b & SIZE_REQ_MASK) == 8'h00);
            OFS_REGION:    bad = ((b & REGION_MASK) != 8'h00);
            OFS_LAST:      bad = (b != LAST_VALUE && b != 8'hff);
            default:       bad = 1'b0;
        endcase
        if (bad)
            field_bad = 1'b1;
    end
    endtask

    // Advance the predicted record by one accepted word; queue the verdict
    task score_byte(input logic [7:0] b, input logic st, input bit known,
                    input verdict_t typed);
        verdict_t v;
    begin
        if (st)
            clear_record();
        if (rec_pos <= OFS_LAST)
        begin
            scored_words++;
            scan_name(b);
            check_field(rec_pos, b);
            if (rec_pos == OFS_LAST)
            begin
                rec_pos  = OFS_DONE;
                v.status = scan_done ? scan_code : NAME_REJECT;
                v.fok    = !field_bad;
                v.ok     = v.fok && (v.status == NAME_OK);
                pending_verdicts.push_back(known ? typed : v);
            end
            else
                rec_pos = rec_pos + 5'd1;
        end
    end
    endtask

    task send_word(input logic [7:0] b, input logic st, input bit known,
                   input verdict_t typed);
    begin
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        byte_valid   <= 1'b1;
        byte_value   <= b;
        record_start <= st;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        score_byte(b, st, known, typed);
    end
    endtask

    function automatic record_row_t dir_row(input bit [8*19-1:0] nm, input bit [63:0] fl,
                                            input bit st, input int nb, input int jk,
                                            input bit kn, input verdict_t w);
        record_row_t r;
        r.name   = nm;
        r.fld    = fl;
        r.start  = st;
        r.nbytes = nb[4:0];
        r.junk   = jk[3:0];
        r.known  = kn;
        r.want   = w;
        return r;
    endfunction

    function automatic logic [7:0] lead_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h80, 8'h9f));
        return 8'($urandom_range(8'he0, 8'hff));
    endfunction

    // Fill offsets 0..18 with name tokens; special mode forces the count-11 pair
    task fill_name(input bit special);
        int i;
        int w;
    begin
        i = 0;
        if (special)
        begin
            for (i = 0; i < 11; i++)
                rec_buf[i] = 8'($urandom_range(8'h20, 8'h7f));
            rec_buf[11] = lead_byte();
            case ($urandom_range(0, 2))
                0:       rec_buf[12] = 8'h00;
                1:       rec_buf[12] = 8'($urandom_range(1, 31));
                default: rec_buf[12] = 8'($urandom_range(0, 255));
            endcase
            i = 13;
        end
        while (i < 19)
        begin
            w = $urandom_range(0, 99);
            if (w < 60)
                rec_buf[i] = 8'($urandom_range(8'h20, 8'h7f));
            else if (w < 75)
            begin
                rec_buf[i] = lead_byte();
                if (i < 18)
                begin
                    i++;
                    if ($urandom_range(0, 7) == 0)
                        rec_buf[i] = 8'($urandom_range(0, 31));
                    else
                        rec_buf[i] = 8'($urandom_range(32, 255));
                end
            end
            else if (w < 85)
                rec_buf[i] = 8'($urandom_range(8'ha0, 8'hdf));
            else if (w < 93)
                rec_buf[i] = 8'h00;
            else if (w < 97)
                rec_buf[i] = 8'($urandom_range(1, 31));
            else
                rec_buf[i] = 8'($urandom_range(0, 255));
            i++;
        end
    end
    endtask

    // Mostly legal field values with random content; now and then any byte
    task fill_fields;
        logic [7:0] r;
    begin
        rec_buf[19] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        rec_buf[20] = 8'h00;
        rec_buf[21] = 8'($urandom_range(0, 255)) & 8'hfc;
        case ($urandom_range(0, 3))
            0:
            begin
                rec_buf[22] = 8'h00;
                rec_buf[23] = 8'h00;
            end
            1:
            begin
                rec_buf[22] = 8'hff;
                rec_buf[23] = 8'hff;
            end
            default:
            begin
                rec_buf[22] = 8'($urandom_range(0, 8'hc0)) & 8'hf0;
                rec_buf[23] = 8'($urandom_range(0, 255)) & 8'hfb;
            end
        endcase
        r = 8'($urandom_range(0, 255)) & 8'h31;
        if ((r & SIZE_REQ_MASK) == 8'h00)
            r = r | 8'h10;
        rec_buf[24] = r;
        rec_buf[25] = 8'($urandom_range(0, 255)) & 8'hb0;
        rec_buf[26] = $urandom_range(0, 1) ? 8'hff : LAST_VALUE;
        for (int k = 19; k < 27; k++)
            if ($urandom_range(0, 11) == 0)
                rec_buf[k] = 8'($urandom_range(0, 255));
    end
    endtask

    // Verdict side: random stall bursts and in-order comparison
    int stall_left = 0;
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (verdict_valid && !verdict_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: verdict with none expected: ok=%0d status=%0d fok=%0d",
                         $time, header_ok, name_status, fields_ok);
                errors++;
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (header_ok !== exp_v.ok)
                begin
                    $display("%0t: header_ok expected %0d actual %0d",
                             $time, exp_v.ok, header_ok);
                    errors++;
                end
                if (name_status !== exp_v.status)
                begin
                    $display("%0t: name_status expected %0d actual %0d",
                             $time, exp_v.status, name_status);
                    errors++;
                end
                if (fields_ok !== exp_v.fok)
                begin
                    $display("%0t: fields_ok expected %0d actual %0d",
                             $time, exp_v.fok, fields_ok);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            verdict_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 7);
            verdict_stall <= 1'b1;
        end
        else
            verdict_stall <= 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        record_row_t row;
        logic [7:0]  b;
        int          kind;
        int          len;
        verdict_t    none;

        none = '0;
        clear_record();

        dir_tab[0]  = dir_row(NM_A, FG, 1'b0, 27, 0, 1'b1, {1'b1, NAME_OK, 1'b1});
        dir_tab[1]  = dir_row(NM_A, {8{8'hff}}, 1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[2]  = dir_row({8'h00, "BCDEFGHIJKLMNOPQRS"}, FG, 1'b1, 27, 0,
                              1'b1, {1'b0, NAME_REJECT, 1'b1});
        dir_tab[3]  = dir_row({8'h01, "BCDEFGHIJKLMNOPQRS"}, FG, 1'b1, 27, 0,
                              1'b1, {1'b0, NAME_REJECT, 1'b1});
        dir_tab[4]  = dir_row({"ABCDEFGHIJK", 8'h81, 8'h05, "LMNOPQ"}, FG, 1'b1, 27, 0,
                              1'b1, {1'b0, NAME_EARLY, 1'b1});
        dir_tab[5]  = dir_row({"ABCDEFGHIJK", 8'h9f, 8'h00, "LMNOPQ"}, FG, 1'b1, 27, 0,
                              1'b0, none);
        dir_tab[6]  = dir_row({"ABCDE", 8'h81, 8'h10, "FGHIJKLMNOPQ"}, FG, 1'b1, 27, 0,
                              1'b0, none);
        dir_tab[7]  = dir_row({8'he0, 8'h40, 8'hff, 8'hfe, 8'h80, 8'h20, 8'h9f, 8'h7f,
                               8'he5, 8'ha0, 8'hfa, 8'hdf, 8'h81, 8'h80, 8'h82, 8'hff,
                               "XYZ"}, FG, 1'b1, 27, 0, 1'b0, none);
        dir_tab[8]  = dir_row({{16{8'hb1}}, "ABC"}, FG, 1'b1, 27, 0, 1'b0, none);
        dir_tab[9]  = dir_row({"AB", 8'h00, 8'h00, "CDEFGHIJKLMNOPQ"}, FG, 1'b1, 27, 0,
                              1'b0, none);
        dir_tab[10] = dir_row({8'h20, 8'h7f, 8'ha0, 8'hdf, 8'h1f, "ABCDEFGHIJKLMN"}, FG,
                              1'b1, 27, 0, 1'b0, none);
        dir_tab[11] = dir_row(NM_A, {8'hff, 8'h00, 8'hfc, 8'hff, 8'hff, 8'h31, 8'hb0, 8'hff},
                              1'b1, 27, 0, 1'b1, {1'b1, NAME_OK, 1'b1});
        dir_tab[12] = dir_row(NM_A, {8'h00, 8'h00, 8'h00, 8'hc1, 8'h00, 8'h30, 8'h00, 8'h33},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[13] = dir_row(NM_A, {8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h30, 8'h00, 8'h33},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[14] = dir_row(NM_A, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h33},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[15] = dir_row(NM_A, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h4f, 8'h33},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[16] = dir_row(NM_A, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h00, 8'h00},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[17] = dir_row(NM_A, {8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h00, 8'h33},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        dir_tab[18] = dir_row(NM_A, {8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h30, 8'h00, 8'h33},
                              1'b1, 27, 0, 1'b1, {1'b0, NAME_OK, 1'b0});
        // Cut short, then restarted by the next row
        dir_tab[19] = dir_row(NM_A, FG, 1'b1, 10, 0, 1'b0, none);
        // Trailing words past offset 26 must be dropped
        dir_tab[20] = dir_row(NM_A, FG, 1'b1, 27, 5, 1'b1, {1'b1, NAME_OK, 1'b1});
        dir_tab[21] = dir_row(NM_A, FG, 1'b0, 3, 0, 1'b0, none);
        dir_tab[22] = dir_row({8'he0, 8'h1f, "ABCDEFGHIJKLMNOPQ"}, FG, 1'b1, 27, 0,
                              1'b0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[r])
        begin
            row = dir_tab[r];
            for (int i = 0; i < row.nbytes; i++)
            begin
                b = (i < 19) ? row.name[8*(18-i) +: 8] : row.fld[8*(26-i) +: 8];
                send_word(b, row.start && (i == 0), row.known, row.want);
            end
            repeat (row.junk)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, none);
        end

        while (scored_words < ITEMS)
        begin
            // Quiet tail: no idling on either side
            idle_on = (scored_words < ITEMS * 85 / 100);
            kind = $urandom_range(0, 19);
            fill_name(kind < 2);
            fill_fields();
            len = (kind == 2) ? $urandom_range(1, 26) : 27;
            for (int i = 0; i < len; i++)
                send_word(rec_buf[i], (i == 0) && (kind != 3), 1'b0, none);
            if (kind == 4 || kind == 5)
                repeat ($urandom_range(1, 6))
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              1'b0, none);
        end
        byte_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
